// ===== sv/rwp_pkg.sv =====
// Package for the ROM word packer: shared types, constants and the byte
// select and checksum patch functions. No dependencies.
`default_nettype none

package rwp_pkg;

  localparam int unsigned WordW       = 10;
  localparam int unsigned CapW        = 16;
  localparam int unsigned GroupWords  = 4;
  localparam int unsigned GroupBytes  = 5;
  localparam logic [CapW-1:0] CapReset = 16'd5120;
  localparam logic [CapW-1:0] GroupBytesC = 16'd5;

  typedef logic [WordW-1:0] rwp_word_t;
  typedef logic [GroupWords-1:0][WordW-1:0] rwp_group_t;

  // Result list of one input word: up to two groups, then an optional error.
  typedef struct packed {
    rwp_group_t  grp0;
    rwp_group_t  grp1;
    logic [1:0]  num_groups;
    logic        err;
    logic        fin;
    logic [3:0]  num_results;
  } rwp_desc_t;

  // Byte k of a packed group: top bits first, then low bytes of word 3 to 0.
  function automatic logic [7:0] rwp_group_byte(input rwp_group_t g, input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = {g[3][9:8], g[2][9:8], g[1][9:8], g[0][9:8]};
      3'd1:    b = g[3][7:0];
      3'd2:    b = g[2][7:0];
      3'd3:    b = g[1][7:0];
      3'd4:    b = g[0][7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Two's complement of the sum, 10 bits wide.
  function automatic rwp_word_t rwp_patch(input rwp_word_t s);
    return rwp_word_t'(~s + 10'd1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/rwp_ifs.sv =====
// Handshake channels of the ROM word packer: word input, byte output and
// the capacity write port. Depends on rwp_pkg.
`default_nettype none

interface rwp_in_if import rwp_pkg::*; ();
  logic      valid;
  logic      ready;
  rwp_word_t rom_word;
  logic      final_word;
  modport source (output valid, output rom_word, output final_word, input ready);
  modport sink   (input valid, input rom_word, input final_word, output ready);
endinterface

interface rwp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       image_end;
  logic       overflow_error;
  modport source (output valid, output out_byte, output run_end, output image_end,
                  output overflow_error, input ready);
  modport sink   (input valid, input out_byte, input run_end, input image_end,
                  input overflow_error, output ready);
endinterface

interface rwp_cfg_if import rwp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] wdata;
  modport source (output valid, output wdata, input ready);
  modport sink   (input valid, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/rwp_serializer.sv =====
// Result queue and byte serializer: holds up to two result lists and sends
// them out one transfer per cycle, while the receiver is ready, through an output register.
// Depends on rwp_pkg and rwp_out_if.
`default_nettype none

module rwp_serializer import rwp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire rwp_desc_t desc_i,
  output logic           full_o,
  rwp_out_if.source      out_o
);

  rwp_desc_t  fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic [3:0] idx_q;
  rwp_desc_t  head;
  logic       load, last, pop;
  logic [3:0] grp_results;
  logic [3:0] idx_hi;
  logic [7:0] byte_sel;
  logic       err_slot;

  logic       out_v_q;
  logic [7:0] byte_q;
  logic       run_end_q, image_end_q, err_q;

  assign head     = fifo_q[rd_ptr_q];
  assign load     = (cnt_q != 2'd0) && (!out_v_q || out_o.ready);
  assign last     = (idx_q == (head.num_results - 4'd1));
  assign pop      = load && last;
  assign full_o   = (cnt_q == 2'd2);
  assign cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};

  // Pick the byte for the current slot of the head list
  assign grp_results = {head.num_groups, 2'b00} + {2'b00, head.num_groups};
  assign idx_hi      = idx_q - 4'd5;
  assign err_slot    = (idx_q >= grp_results);
  always_comb begin
    if (err_slot) begin
      byte_sel = 8'h00;
    end else if (idx_q < 4'd5) begin
      byte_sel = rwp_group_byte(head.grp0, idx_q[2:0]);
    end else begin
      byte_sel = rwp_group_byte(head.grp1, idx_hi[2:0]);
    end
  end

  // Queue pointers, slot counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      idx_q    <= 4'd0;
      out_v_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        idx_q    <= 4'd0;
      end else if (load) begin
        idx_q <= idx_q + 4'd1;
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Queue storage and output payload
  always_ff @(posedge clk_i) begin
    if (push_i) fifo_q[wr_ptr_q] <= desc_i;
    if (load) begin
      byte_q      <= byte_sel;
      err_q       <= err_slot;
      run_end_q   <= last;
      image_end_q <= last && head.fin;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.out_byte       = byte_q;
  assign out_o.run_end        = run_end_q;
  assign out_o.image_end      = image_end_q;
  assign out_o.overflow_error = err_q;

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full result queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result queue count out of range");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && err_q) |-> (run_end_q && byte_q == 8'h00))
    else $error("error result not last or not zero");

endmodule

`default_nettype wire

// ===== sv/rom_word_packer_with_checksum.sv =====
// ROM word packer: four 10-bit words to five bytes, one group held back,
// end-around-carry checksum patched into the last complete group.
// The first byte of a result list passes through the result queue, then the output register.
// Throughput: one word per cycle while the two-list result queue has room;
// the byte serializer drains one result per cycle while the receiver is ready, five per group.
// Reset (async, low): empty image, capacity 5120, queue and output empty.
// Depends on rwp_pkg, rwp_ifs and rwp_serializer.
`default_nettype none

module rom_word_packer_with_checksum import rwp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rwp_in_if.sink    in_i,
  rwp_cfg_if.sink   cfg_i,
  rwp_out_if.source out_o
);

  logic [CapW-1:0] cap_q;
  rwp_group_t      held_q, held_d, fill_q, fill_d;
  logic [1:0]      pos_q, pos_d;
  logic            held_v_q, held_v_d;
  rwp_word_t       sum_q, sum_d, held_sum_q, held_sum_d;
  logic [CapW-1:0] be_q, be_d;
  logic            drop_q, drop_d;

  logic            acc, fin, full;
  rwp_word_t       w;
  logic [WordW:0]  sum_raw;
  rwp_group_t      cur, ga, gb;
  logic            a_emit, b_emit, ok;
  logic [CapW-1:0] be1;
  logic            push;
  rwp_desc_t       desc;
  logic [1:0]      ng;

  assign acc         = in_i.valid && in_i.ready;
  assign fin         = in_i.final_word;
  assign w           = in_i.rom_word;
  assign in_i.ready  = !full;
  assign cfg_i.ready = 1'b1;
  assign sum_raw     = {1'b0, sum_q} + {1'b0, w};
  assign be1         = a_emit ? be_q + GroupBytesC : be_q;

  // Group, checksum and capacity update for one accepted word
  always_comb begin
    held_d     = held_q;
    fill_d     = fill_q;
    pos_d      = pos_q;
    held_v_d   = held_v_q;
    sum_d      = sum_q;
    held_sum_d = held_sum_q;
    be_d       = be_q;
    drop_d     = drop_q;
    cur        = fill_q;
    cur[3]     = w;
    ga         = held_q;
    gb         = cur;
    a_emit     = 1'b0;
    b_emit     = 1'b0;
    ok         = 1'b1;
    push       = 1'b0;
    if (acc && !drop_q) begin
      fill_d[pos_q] = w;
      sum_d = sum_raw[WordW] ? sum_raw[WordW-1:0] + 10'd1 : sum_raw[WordW-1:0];
      if (pos_q == 2'd3) begin
        pos_d = 2'd0;
        if (held_v_q) begin
          if ({1'b0, be_q} + 17'd5 <= {1'b0, cap_q}) a_emit = 1'b1;
          else ok = 1'b0;
        end
        if (ok) begin
          if (fin) begin
            gb[3] = rwp_patch(sum_q);
            if ({1'b0, be1} + 17'd5 <= {1'b0, cap_q}) b_emit = 1'b1;
            else ok = 1'b0;
          end else begin
            held_d     = cur;
            held_sum_d = sum_q;
            held_v_d   = 1'b1;
          end
        end
      end else begin
        pos_d = pos_q + 2'd1;
        if (fin && held_v_q) begin
          ga[3] = rwp_patch(held_sum_q);
          if ({1'b0, be_q} + 17'd5 <= {1'b0, cap_q}) a_emit = 1'b1;
          else ok = 1'b0;
        end
      end
      be_d = b_emit ? be1 + GroupBytesC : be1;
      if (!ok && !fin) drop_d = 1'b1;
      push = a_emit || b_emit || !ok;
    end
    // Start a new image after the last word
    if (acc && fin) begin
      pos_d      = 2'd0;
      held_v_d   = 1'b0;
      sum_d      = '0;
      held_sum_d = '0;
      be_d       = '0;
      drop_d     = 1'b0;
    end
  end

  // Build the result list, first emitted group in the first slot
  assign ng = {1'b0, a_emit} + {1'b0, b_emit};
  always_comb begin
    desc.grp0        = a_emit ? ga : gb;
    desc.grp1        = gb;
    desc.num_groups  = ng;
    desc.err         = !ok;
    desc.fin         = fin;
    desc.num_results = {ng, 2'b00} + {2'b00, ng} + {3'b000, !ok};
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CapReset;
      pos_q      <= 2'd0;
      held_v_q   <= 1'b0;
      sum_q      <= '0;
      held_sum_q <= '0;
      be_q       <= '0;
      drop_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) cap_q <= cfg_i.wdata;
      pos_q      <= pos_d;
      held_v_q   <= held_v_d;
      sum_q      <= sum_d;
      held_sum_q <= held_sum_d;
      be_q       <= be_d;
      drop_q     <= drop_d;
    end
  end

  // Word storage
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    fill_q <= fill_d;
  end

  rwp_serializer u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .full_o (full),
    .out_o  (out_o)
  );

  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && fin) |=> (pos_q == 2'd0 && !held_v_q && !drop_q && be_q == '0))
    else $error("image state not cleared after last word");
  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> !push) else $error("result while dropping words");
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (desc.num_results != 4'd0 && desc.num_results <= 4'd10))
    else $error("bad result list length");

endmodule

`default_nettype wire

// ===== verif/rom_word_packer_with_checksum_tb.sv =====
// Testbench for rom_word_packer_with_checksum: drives ROM words, predicts the
// packed byte stream and checks every output transfer. Depends on rwp_pkg,
// rwp_ifs and the block's RTL.
`default_nettype none

module rom_word_packer_with_checksum_tb;
  import rwp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned SettleCycles  = 8;

  // One byte of the packed image as it leaves the block
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       image_end;
    logic       overflow_error;
  } packed_byte_t;

  logic clk_i;
  logic rst_ni;

  rwp_in_if  in_if ();
  rwp_cfg_if cfg_if ();
  rwp_out_if out_if ();

  rom_word_packer_with_checksum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Predicted image state
  rwp_group_t      held_grp;
  rwp_group_t      fill_grp;
  logic [1:0]      fill_pos;
  bit              held_ok;
  rwp_word_t       sum_run;
  rwp_word_t       held_sum_before;
  logic [CapW-1:0] bytes_out;
  bit              dropping;
  logic [CapW-1:0] capacity_cfg;

  packed_byte_t pending_bytes[$];
  packed_byte_t want_byte;
  int           mismatch_count;

  int src_idle_pct;
  int sink_idle_pct;
  int sink_hold_left;

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Return the image state to its start
  function automatic void clear_image();
    held_grp        = '0;
    fill_grp        = '0;
    fill_pos        = 2'd0;
    held_ok         = 1'b0;
    sum_run         = '0;
    held_sum_before = '0;
    bytes_out       = '0;
    dropping        = 1'b0;
  endfunction

  // Two's complement of the running sum before the last word, patched in as that word
  function automatic rwp_word_t checksum_fixup(input rwp_word_t sum_before);
    logic [WordW:0] neg;
    neg = {1'b0, ~sum_before} + 1'b1;
    return neg[WordW-1:0];
  endfunction

  // Queue the five bytes of a group if it fits the capacity; report whether it fits
  function automatic bit stage_group_bytes(input rwp_group_t g);
    packed_byte_t b;
    if ({1'b0, bytes_out} + 17'd5 > {1'b0, capacity_cfg}) return 1'b0;
    b = '0;
    b.out_byte = {g[3][9:8], g[2][9:8], g[1][9:8], g[0][9:8]};
    pending_bytes.push_back(b);
    for (int k = 3; k >= 0; k--) begin
      b.out_byte = g[k][7:0];
      pending_bytes.push_back(b);
    end
    bytes_out = bytes_out + GroupBytesC;
    return 1'b1;
  endfunction

  // Work out the bytes that one accepted word causes
  function automatic void pack_word(input rwp_word_t w, input bit fin);
    int           first_idx;
    bit           ok;
    logic [1:0]   pos;
    rwp_word_t    sum_prev;
    logic [WordW:0] s;
    packed_byte_t b;
    first_idx = pending_bytes.size();
    ok = 1'b1;
    if (dropping) begin
      if (fin) clear_image();
      return;
    end
    pos = fill_pos;
    fill_grp[pos] = w;
    sum_prev = sum_run;
    s = {1'b0, sum_run} + w;
    if (s[WordW]) s = {1'b0, s[WordW-1:0]} + 1'b1;
    sum_run = s[WordW-1:0];
    if (pos == 2'd3) begin
      fill_pos = 2'd0;
      if (held_ok) ok = stage_group_bytes(held_grp);
      if (ok) begin
        if (fin) begin
          fill_grp[3] = checksum_fixup(sum_prev);
          ok = stage_group_bytes(fill_grp);
        end else begin
          held_grp        = fill_grp;
          held_sum_before = sum_prev;
          held_ok         = 1'b1;
        end
      end
    end else begin
      fill_pos = pos + 2'd1;
      if (fin && held_ok) begin
        held_grp[3] = checksum_fixup(held_sum_before);
        ok = stage_group_bytes(held_grp);
      end
    end
    if (!ok) begin
      b = '0;
      b.overflow_error = 1'b1;
      pending_bytes.push_back(b);
      if (!fin) dropping = 1'b1;
    end
    if (pending_bytes.size() > first_idx) begin
      b = pending_bytes.pop_back();
      b.run_end   = 1'b1;
      b.image_end = fin;
      pending_bytes.push_back(b);
    end
    if (fin) clear_image();
  endfunction

  // Offer one word, with random idle cycles ahead of it, and wait for the transfer
  task automatic send_word(input rwp_word_t w, input bit fin);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_if.valid      <= 1'b1;
    in_if.rom_word   <= w;
    in_if.final_word <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    pack_word(w, fin);
  endtask

  // Drop valid and wait until every predicted byte has arrived
  task automatic wait_all_bytes();
    in_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the capacity register; the block must be idle
  task automatic set_capacity(input logic [CapW-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.wdata <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    capacity_cfg = v;
  endtask

  function automatic rwp_word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rwp_word_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // Full groups, a partial tail, an image with no complete group, zero checksum
  task automatic test_directed_extremes();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_word(10'h3FF, 1'b0);
    send_word(10'h3FF, 1'b0);
    send_word(10'h3FF, 1'b0);
    send_word(10'h3FF, 1'b0);
    send_word(10'h000, 1'b0);
    send_word(10'h155, 1'b0);
    send_word(10'h2AA, 1'b0);
    send_word(10'h3FF, 1'b1);
    // held group is the final complete one; sum before its last word is zero
    send_word(10'h000, 1'b0);
    send_word(10'h000, 1'b0);
    send_word(10'h000, 1'b0);
    send_word(10'h3FF, 1'b0);
    send_word(10'h3FF, 1'b0);
    send_word(10'h001, 1'b1);
    // lone final word: no complete group, no bytes
    send_word(10'h200, 1'b1);
    wait_all_bytes();
  endtask

  // Capacity of zero: error on the first group, drop until the final word
  task automatic test_directed_overflow();
    set_capacity(16'd0);
    for (int i = 0; i < 8; i++) send_word(rwp_word_t'(i * 97), 1'b0);
    send_word(10'h3FF, 1'b0);
    send_word(10'h000, 1'b1);
    wait_all_bytes();
  endtask

  // Random images, mostly well formed, with some loose words as noise
  task automatic test_random_phase(input int src_pct, input int sink_pct,
                                   input logic [CapW-1:0] cap, input int num_items);
    int sent;
    int len;
    wait_all_bytes();
    set_capacity(cap);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < num_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(rand_word(), ($urandom_range(0, 3) == 0));
        sent++;
      end else begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 32);
        for (int i = 1; i <= len; i++) send_word(rand_word(), (i == len));
        sent += len;
      end
      // hold the sender until the output has caught up
      if ($urandom_range(0, 29) == 0) wait_all_bytes();
    end
    wait_all_bytes();
  endtask

  // Hold the receiver off long enough that the block stalls its input
  task automatic test_backpressure_fill();
    wait_all_bytes();
    set_capacity(16'hFFFF);
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    sink_hold_left = 300;
    for (int i = 1; i <= 40; i++) send_word(rand_word(), (i % 20 == 0));
    wait_all_bytes();
  endtask

  // Receiver: random idling plus an optional long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_left > 0) begin
        out_if.ready <= 1'b0;
        sink_hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Compare each output transfer with the oldest predicted byte
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected output transfer: out_byte %0h", out_if.out_byte);
        mismatch_count++;
      end else begin
        want_byte = pending_bytes.pop_front();
        if (out_if.out_byte !== want_byte.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want_byte.out_byte, out_if.out_byte);
          mismatch_count++;
        end
        if (out_if.run_end !== want_byte.run_end) begin
          $error("run_end: expected %0b, got %0b", want_byte.run_end, out_if.run_end);
          mismatch_count++;
        end
        if (out_if.image_end !== want_byte.image_end) begin
          $error("image_end: expected %0b, got %0b", want_byte.image_end, out_if.image_end);
          mismatch_count++;
        end
        if (out_if.overflow_error !== want_byte.overflow_error) begin
          $error("overflow_error: expected %0b, got %0b",
                 want_byte.overflow_error, out_if.overflow_error);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.rom_word   = '0;
    in_if.final_word = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.wdata     = '0;
    mismatch_count   = 0;
    src_idle_pct     = 0;
    sink_idle_pct    = 0;
    sink_hold_left   = 0;
    capacity_cfg     = CapReset;
    clear_image();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_directed_overflow();
    test_random_phase(23, 48, 16'hFFFF, 40);
    test_random_phase(48, 23, 16'($urandom_range(5, 40)), 40);
    test_random_phase(0, 0, 16'($urandom_range(41, 300)), 40);
    test_backpressure_fill();
    test_random_phase(23, 48, CapReset, 40);

    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
